/* rtl/core/qgm_pkg.sv */
// Shared types and constants for the single-qubit gate matrix generator.
// No dependencies; used by qgm_cordic and qubit_gate_matrix_generator.
package qgm_pkg;

	// Angles inside the core are 32-bit fractions of a full turn.
	localparam int TURN_W = 32;
	// CORDIC coordinates are Q2.30 with headroom; z carries the residual angle.
	localparam int CX_W = 34;
	// Trimmed CORDIC result, Q2.30.
	localparam int TRIG_W = 32;
	localparam int OUT_W = 16;

	localparam int CORDIC_STEPS = 24;
	// Prep register, one register per micro-rotation, output register.
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;

	// Pre-scaled start vector so the result needs no gain correction.
	localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// atan(2^-i) as a fraction of a full turn, 32-bit.
	localparam logic [TURN_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef enum logic [2:0] {
		CMD_RX = 3'd0,
		CMD_RY = 3'd1,
		CMD_RZ = 3'd2,
		CMD_P  = 3'd3,
		CMD_U  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] m00_re;
		logic signed [OUT_W-1:0] m00_im;
		logic signed [OUT_W-1:0] m01_re;
		logic signed [OUT_W-1:0] m01_im;
		logic signed [OUT_W-1:0] m10_re;
		logic signed [OUT_W-1:0] m10_im;
		logic signed [OUT_W-1:0] m11_re;
		logic signed [OUT_W-1:0] m11_im;
	} mat_t;

endpackage

/* rtl/core/qgm_cordic.sv */
// Pipelined CORDIC sine/cosine: one micro-rotation per register stage.
// Depends on qgm_pkg. Takes a new angle every cycle.
module qgm_cordic (
	input  logic                               clk,
	input  logic [qgm_pkg::TURN_W-1:0]         ang,
	output logic signed [qgm_pkg::TRIG_W-1:0]  cs,
	output logic signed [qgm_pkg::TRIG_W-1:0]  sn
);
	import qgm_pkg::*;

	logic [TURN_W-1:0]      ang_q1;
	logic                   flip_pre;
	logic [TURN_W-1:0]      ang_fold;

	logic signed [CX_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [CX_W-1:0] z_s [CORDIC_STEPS+1];
	logic                   flip_s [CORDIC_STEPS+1];

	// Fold the second and third quadrants onto the first and fourth; undo by negation.
	assign ang_q1   = ang + 32'h4000_0000;
	assign flip_pre = ang_q1[TURN_W-1];
	assign ang_fold = flip_pre ? (ang + 32'h8000_0000) : ang;

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_GAIN;
		y_s[0]    <= '0;
		z_s[0]    <= CX_W'(signed'(ang_fold));
		flip_s[0] <= flip_pre;
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		logic signed [CX_W-1:0] dx;
		logic signed [CX_W-1:0] dy;
		logic signed [CX_W-1:0] at;

		assign dx = x_s[k] >>> 0;
		assign dy = y_s[k] >>> k;
		assign at = CX_W'(ATAN_TURN[k]);

		always_ff @(posedge clk) begin
			if (!z_s[k][CX_W-1]) begin
				x_s[k+1] <= x_s[k] - dy;
				y_s[k+1] <= y_s[k] + (dx >>> k);
				z_s[k+1] <= z_s[k] - at;
			end else begin
				x_s[k+1] <= x_s[k] + dy;
				y_s[k+1] <= y_s[k] - (dx >>> k);
				z_s[k+1] <= z_s[k] + at;
			end
			flip_s[k+1] <= flip_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (flip_s[CORDIC_STEPS]) begin
			cs <= TRIG_W'(-x_s[CORDIC_STEPS]);
			sn <= TRIG_W'(-y_s[CORDIC_STEPS]);
		end else begin
			cs <= TRIG_W'(x_s[CORDIC_STEPS]);
			sn <= TRIG_W'(y_s[CORDIC_STEPS]);
		end
	end

endmodule

/* rtl/core/qubit_gate_matrix_generator.sv */
// Single-qubit gate matrix generator: Rx, Ry, Rz, P and U as 2x2 complex Q2.14.
// Depends on qgm_pkg and qgm_cordic (four instances).
//
// channel   direction  signals                         handshake
// request   in         cmd, theta, phi, lam            start & !busy
// result    out        m00_re .. m11_im                done, one cycle
//
// One request enters every cycle; busy stays low.
// From the accepting edge, a request passes the input register, the 26 CORDIC stages
// (prep, 24 micro-rotations, output), the product stage and the round/output stage to done.
// Reset clears the valid bits only; payload registers are not reset.
// The receiver cannot stall, so nothing in the pipe is ever held.
module qubit_gate_matrix_generator #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          cmd,
	input  logic [ANGLE_BITS-1:0]               theta,
	input  logic [ANGLE_BITS-1:0]               phi,
	input  logic [ANGLE_BITS-1:0]               lam,
	output logic                                done,
	output logic signed [qgm_pkg::OUT_W-1:0]    m00_re,
	output logic signed [qgm_pkg::OUT_W-1:0]    m00_im,
	output logic signed [qgm_pkg::OUT_W-1:0]    m01_re,
	output logic signed [qgm_pkg::OUT_W-1:0]    m01_im,
	output logic signed [qgm_pkg::OUT_W-1:0]    m10_re,
	output logic signed [qgm_pkg::OUT_W-1:0]    m10_im,
	output logic signed [qgm_pkg::OUT_W-1:0]    m11_re,
	output logic signed [qgm_pkg::OUT_W-1:0]    m11_im
);
	import qgm_pkg::*;

	localparam int    SH_Q30  = 30 - FRAC_BITS;
	localparam int    SH_PRD  = 60 - FRAC_BITS;
	localparam longint RND_Q30 = (SH_Q30 > 0) ? (64'sd1 <<< (SH_Q30 - 1)) : 64'sd0;
	localparam longint RND_PRD = 64'sd1 <<< (SH_PRD - 1);
	localparam logic signed [CX_W-1:0] ONE_Q = CX_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [OUT_W-1:0] ONE_O = OUT_W'(64'sd1 <<< FRAC_BITS);
	localparam int PROD_W = 2 * TRIG_W;

	function automatic logic [TURN_W-1:0] to_turn(input logic [ANGLE_BITS-1:0] a);
		return TURN_W'(a) << (TURN_W - ANGLE_BITS);
	endfunction

	// Round half up from Q2.30 and clamp to +-1.0.
	function automatic logic signed [TRIG_W-1:0] sat_q30(input logic signed [TRIG_W-1:0] v);
		logic signed [CX_W-1:0] t;
		logic signed [CX_W-1:0] r;
		t = CX_W'(v) + CX_W'(RND_Q30);
		r = t >>> SH_Q30;
		if (r > ONE_Q)
			r = ONE_Q;
		if (r < -ONE_Q)
			r = -ONE_Q;
		return TRIG_W'(r);
	endfunction

	// Round half up from the Q4.60 product and clamp to +-1.0.
	function automatic logic signed [TRIG_W-1:0] sat_prd(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W:0] t;
		logic signed [PROD_W:0] r;
		t = (PROD_W+1)'(p) + (PROD_W+1)'(RND_PRD);
		r = t >>> SH_PRD;
		if (r > (PROD_W+1)'(ONE_Q))
			r = (PROD_W+1)'(ONE_Q);
		if (r < -(PROD_W+1)'(ONE_Q))
			r = -(PROD_W+1)'(ONE_Q);
		return TRIG_W'(r);
	endfunction

	// Input stage
	logic              vld_s1;
	logic [2:0]        cmd_s1;
	logic [TURN_W-1:0] half_s1;
	logic [TURN_W-1:0] alt_s1;
	logic [TURN_W-1:0] lam_s1;
	logic [TURN_W-1:0] sum_s1;

	logic              req;

	assign busy = 1'b0;
	assign req  = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= cmd;
		half_s1 <= to_turn(theta) >> 1;
		alt_s1  <= (cmd == CMD_RZ) ? to_turn(theta) : to_turn(phi);
		lam_s1  <= to_turn(lam);
		sum_s1  <= to_turn(phi) + to_turn(lam);
	end

	// Sine/cosine units
	logic signed [TRIG_W-1:0] c_w, s_w, pc_w, ps_w, lc_w, ls_w, sc_w, ss_w;

	qgm_cordic u_half (.clk(clk), .ang(half_s1), .cs(c_w),  .sn(s_w));
	qgm_cordic u_alt  (.clk(clk), .ang(alt_s1),  .cs(pc_w), .sn(ps_w));
	qgm_cordic u_lam  (.clk(clk), .ang(lam_s1),  .cs(lc_w), .sn(ls_w));
	qgm_cordic u_sum  (.clk(clk), .ang(sum_s1),  .cs(sc_w), .sn(ss_w));

	// Kind and valid ride alongside the CORDIC stages
	logic       vld_sd [CORDIC_LAT];
	logic [2:0] cmd_sd [CORDIC_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORDIC_LAT; i++)
				vld_sd[i] <= 1'b0;
		end else begin
			vld_sd[0] <= vld_s1;
			for (int i = 1; i < CORDIC_LAT; i++)
				vld_sd[i] <= vld_sd[i-1];
		end
	end

	always_ff @(posedge clk) begin
		cmd_sd[0] <= cmd_s1;
		for (int i = 1; i < CORDIC_LAT; i++)
			cmd_sd[i] <= cmd_sd[i-1];
	end

	// Product stage
	logic                     vld_s3;
	logic [2:0]               cmd_s3;
	logic signed [TRIG_W-1:0] c_s3, s_s3, pc_s3, ps_s3;
	logic signed [PROD_W-1:0] lcs_s3, lss_s3, pcs_s3, pss_s3, scc_s3, ssc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_sd[CORDIC_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3 <= cmd_sd[CORDIC_LAT-1];
		c_s3   <= c_w;
		s_s3   <= s_w;
		pc_s3  <= pc_w;
		ps_s3  <= ps_w;
		lcs_s3 <= lc_w * s_w;
		lss_s3 <= ls_w * s_w;
		pcs_s3 <= pc_w * s_w;
		pss_s3 <= ps_w * s_w;
		scc_s3 <= sc_w * c_w;
		ssc_s3 <= ss_w * c_w;
	end

	// Round, clamp and select
	logic signed [TRIG_W-1:0] c_r, s_r, pc_r, ps_r;
	logic signed [TRIG_W-1:0] lcs_r, lss_r, pcs_r, pss_r, scc_r, ssc_r;
	mat_t                     mat_d;
	mat_t                     mat_s4;
	logic                     vld_s4;

	always_comb begin
		c_r   = sat_q30(c_s3);
		s_r   = sat_q30(s_s3);
		pc_r  = sat_q30(pc_s3);
		ps_r  = sat_q30(ps_s3);
		lcs_r = sat_prd(lcs_s3);
		lss_r = sat_prd(lss_s3);
		pcs_r = sat_prd(pcs_s3);
		pss_r = sat_prd(pss_s3);
		scc_r = sat_prd(scc_s3);
		ssc_r = sat_prd(ssc_s3);

		mat_d = '0;
		case (cmd_s3)
			CMD_RX: begin
				mat_d.m00_re = OUT_W'(c_r);
				mat_d.m01_im = OUT_W'(-s_r);
				mat_d.m10_im = OUT_W'(-s_r);
				mat_d.m11_re = OUT_W'(c_r);
			end
			CMD_RY: begin
				mat_d.m00_re = OUT_W'(c_r);
				mat_d.m01_re = OUT_W'(-s_r);
				mat_d.m10_re = OUT_W'(s_r);
				mat_d.m11_re = OUT_W'(c_r);
			end
			CMD_RZ, CMD_P: begin
				mat_d.m00_re = ONE_O;
				mat_d.m11_re = OUT_W'(pc_r);
				mat_d.m11_im = OUT_W'(ps_r);
			end
			CMD_U: begin
				mat_d.m00_re = OUT_W'(c_r);
				mat_d.m01_re = OUT_W'(-lcs_r);
				mat_d.m01_im = OUT_W'(-lss_r);
				mat_d.m10_re = OUT_W'(pcs_r);
				mat_d.m10_im = OUT_W'(pss_r);
				mat_d.m11_re = OUT_W'(scc_r);
				mat_d.m11_im = OUT_W'(ssc_r);
			end
			default: begin
				// unknown kind: identity
				mat_d.m00_re = ONE_O;
				mat_d.m11_re = ONE_O;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		mat_s4 <= mat_d;
	end

	assign done   = vld_s4;
	assign m00_re = mat_s4.m00_re;
	assign m00_im = mat_s4.m00_im;
	assign m01_re = mat_s4.m01_re;
	assign m01_im = mat_s4.m01_im;
	assign m10_re = mat_s4.m10_re;
	assign m10_im = mat_s4.m10_im;
	assign m11_re = mat_s4.m11_re;
	assign m11_im = mat_s4.m11_im;

endmodule
